/* sv/bfpu_pkg.sv */
// Shared types, widths and helpers for the bit field packer and reader.
package bfpu_pkg;

  // Default sizing of the word store.
  localparam int WORD_BITS_DEF   = 64;
  localparam int STORE_WORDS_DEF = 1024;

  // Fixed field widths at the block boundary.
  localparam int LEN_W  = 7;
  localparam int DATA_W = 64;
  localparam int RPOS_W = 16;
  localparam int POS_W  = 17;

  // Widest bit offset inside a word (words are at most 64 bits).
  localparam int SH_W = 6;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Capacity after reset, in bits.
  localparam logic [POS_W-1:0] CAP_RESET = 17'h10000;

  // Action codes of an input item.
  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  // What the back has to do for one queued item.
  typedef enum logic [1:0] {
    OP_RESULT = 2'd0,
    OP_READ   = 2'd1,
    OP_APPEND = 2'd2
  } op_t;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    op_t                 op;
    logic [POS_W-1:0]    idx;
    logic [SH_W-1:0]     sh;
    logic [LEN_W-1:0]    len;
    logic [DATA_W-1:0]   data;
    logic [POS_W-1:0]    next_rpos;
    logic [POS_W-1:0]    wpos;
    logic                status;
  } job_t;

  // Mask of the low len bits; zero when len is zero.
  function automatic logic [DATA_W-1:0] low_mask(input logic [LEN_W-1:0] len);
    low_mask = {DATA_W{1'b1}} >> (LEN_W'(DATA_W) - len);
  endfunction

endpackage

/* sv/bfpu_front.sv */
// Front end: takes items, tracks the write pointer and classifies each item.
module bfpu_front #(
  parameter int WORD_BITS   = bfpu_pkg::WORD_BITS_DEF,
  parameter int STORE_WORDS = bfpu_pkg::STORE_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [bfpu_pkg::POS_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [bfpu_pkg::LEN_W-1:0]    field_length,
  input  logic [bfpu_pkg::DATA_W-1:0]   field_data,
  input  logic [bfpu_pkg::RPOS_W-1:0]   read_position,
  output logic                          push_valid,
  input  logic                          push_ready,
  output bfpu_pkg::job_t                push_job
);

  localparam int POS_W     = bfpu_pkg::POS_W;
  localparam int LEN_W     = bfpu_pkg::LEN_W;
  localparam int OFF_W     = $clog2(WORD_BITS);
  localparam int DIV_SHIFT = 24;
  localparam int RECIP     = (1 << DIV_SHIFT) / WORD_BITS;
  localparam int RECIP_W   = $clog2(RECIP + 1);
  localparam int PROD_W    = bfpu_pkg::RPOS_W + RECIP_W;

  localparam logic [LEN_W-1:0] W_LEN   = LEN_W'(WORD_BITS);
  localparam logic [LEN_W:0]   W_REACH = (LEN_W + 1)'(WORD_BITS);
  localparam logic [POS_W-1:0] W_POS   = POS_W'(WORD_BITS);
  localparam logic [POS_W:0]   STORE_LIM = (POS_W + 1)'(STORE_WORDS);

  // Control state.
  logic                       s1_valid;
  logic [POS_W-1:0]           capacity;
  logic [POS_W-1:0]           wp;
  logic [POS_W-1:0]           wp_idx;
  logic [OFF_W-1:0]           wp_off;

  // Item held in the classify stage.
  logic                       s1_action;
  logic [LEN_W-1:0]           s1_len;
  logic [bfpu_pkg::DATA_W-1:0] s1_data;
  logic [bfpu_pkg::RPOS_W-1:0] s1_rpos;
  logic [POS_W-1:0]           s1_q;

  logic                       take;
  logic [PROD_W-1:0]          prod;

  // Read position split into word index and bit offset.
  logic [POS_W-1:0]           qw;
  logic [POS_W-1:0]           rem;
  logic                       rfix;
  logic [POS_W-1:0]           rq;
  logic [OFF_W-1:0]           rr;
  logic [POS_W-1:0]           rsum;
  logic [LEN_W:0]             r_reach;
  logic                       rd_err;

  // Append checks against the write pointer.
  logic [POS_W:0]             wsum;
  logic [LEN_W:0]             a_reach;
  logic                       a_err;
  logic                       len_big;
  logic                       len_zero;
  logic                       do_append;

  assign in_ready   = !s1_valid || push_ready;
  assign take       = in_valid && in_ready;
  assign push_valid = s1_valid;

  // Reciprocal multiply gives the word index of the read position, at most one low.
  assign prod = PROD_W'(read_position) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      capacity <= bfpu_pkg::CAP_RESET;
      wp       <= '0;
      wp_idx   <= '0;
      wp_off   <= '0;
    end else begin
      if (cfg_valid) begin
        capacity <= cfg_data;
      end
      if (take) begin
        s1_valid <= 1'b1;
      end else if (push_ready) begin
        s1_valid <= 1'b0;
      end
      // The pointer moves as soon as an accepted append leaves for the queue.
      if (s1_valid && push_ready && do_append) begin
        wp <= wsum[POS_W-1:0];
        if (a_reach >= W_REACH) begin
          wp_idx <= wp_idx + POS_W'(1);
          wp_off <= OFF_W'(a_reach - W_REACH);
        end else begin
          wp_off <= OFF_W'(a_reach);
        end
      end
    end
  end

  // Item payload of the classify stage.
  always_ff @(posedge clk) begin
    if (take) begin
      s1_action <= action;
      s1_len    <= field_length;
      s1_data   <= field_data;
      s1_rpos   <= read_position;
      s1_q      <= POS_W'(prod >> DIV_SHIFT);
    end
  end

  // Finish the division with one compare and subtract, then range-check the read.
  always_comb begin
    qw      = s1_q * W_POS;
    rem     = {1'b0, s1_rpos} - qw;
    rfix    = rem >= W_POS;
    rq      = s1_q + POS_W'(rfix);
    rr      = rfix ? OFF_W'(rem - W_POS) : OFF_W'(rem);
    rsum    = {1'b0, s1_rpos} + POS_W'(s1_len);
    r_reach = (LEN_W + 1)'(rr) + (LEN_W + 1)'(s1_len);
    rd_err  = (rsum > capacity) || ({1'b0, rq} >= STORE_LIM) ||
              ((r_reach > W_REACH) && ({1'b0, rq} + (POS_W + 1)'(1) >= STORE_LIM));
  end

  // Range-check an append at the current write pointer.
  always_comb begin
    wsum    = {1'b0, wp} + (POS_W + 1)'(s1_len);
    a_reach = (LEN_W + 1)'(wp_off) + (LEN_W + 1)'(s1_len);
    a_err   = (wsum > {1'b0, capacity}) || ({1'b0, wp_idx} >= STORE_LIM) ||
              ((a_reach > W_REACH) && ({1'b0, wp_idx} + (POS_W + 1)'(1) >= STORE_LIM));
  end

  // Build the job; everything but the read data is settled here.
  always_comb begin
    len_big   = s1_len > W_LEN;
    len_zero  = s1_len == '0;
    do_append = 1'b0;

    push_job           = '0;
    push_job.op        = bfpu_pkg::OP_RESULT;
    push_job.len       = s1_len;
    push_job.data      = s1_data & bfpu_pkg::low_mask(s1_len);
    push_job.wpos      = wp;

    if (s1_action == bfpu_pkg::ACT_APPEND) begin
      if (len_big) begin
        push_job.status = 1'b1;
      end else if (!len_zero) begin
        if (a_err) begin
          push_job.status = 1'b1;
        end else begin
          push_job.op   = bfpu_pkg::OP_APPEND;
          push_job.idx  = wp_idx;
          push_job.sh   = bfpu_pkg::SH_W'(wp_off);
          push_job.wpos = wsum[POS_W-1:0];
          do_append     = 1'b1;
        end
      end
    end else begin
      push_job.next_rpos = {1'b0, s1_rpos};
      if (len_big) begin
        push_job.status = 1'b1;
      end else if (!len_zero) begin
        if (rd_err) begin
          push_job.status = 1'b1;
        end else begin
          push_job.op        = bfpu_pkg::OP_READ;
          push_job.idx       = rq;
          push_job.sh        = bfpu_pkg::SH_W'(rr);
          push_job.next_rpos = rsum;
        end
      end
    end
  end

endmodule

/* sv/bfpu_queue.sv */
// Short queue of classified items between the front and the back.
module bfpu_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  bfpu_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output bfpu_pkg::job_t pop_job
);

  localparam int DEPTH = bfpu_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  bfpu_pkg::job_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = count != FULL;
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

/* sv/bfpu_back.sv */
// Back end: owns the word store and carries out reads and appends.
module bfpu_back #(
  parameter int WORD_BITS   = bfpu_pkg::WORD_BITS_DEF,
  parameter int STORE_WORDS = bfpu_pkg::STORE_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          job_valid,
  output logic                          job_ready,
  input  bfpu_pkg::job_t                job,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bfpu_pkg::DATA_W-1:0]   read_data,
  output logic [bfpu_pkg::POS_W-1:0]    next_read_position,
  output logic [bfpu_pkg::POS_W-1:0]    write_position,
  output logic                          status
);

  localparam int POS_W  = bfpu_pkg::POS_W;
  localparam int DATA_W = bfpu_pkg::DATA_W;
  localparam int OFF_W  = $clog2(WORD_BITS);
  localparam int ADDR_W = $clog2(STORE_WORDS);
  localparam int FILL_W = $clog2(STORE_WORDS + 1);
  localparam logic [POS_W:0] STORE_LIM = (POS_W + 1)'(STORE_WORDS);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_WR_HI = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                state;
  state_t                state_next;
  logic [FILL_W-1:0]     filled;
  logic [FILL_W-1:0]     filled_next;

  bfpu_pkg::job_t        cur;
  logic [WORD_BITS-1:0]  word_store [STORE_WORDS];
  logic [WORD_BITS-1:0]  rd0;
  logic [WORD_BITS-1:0]  rd1;
  logic [ADDR_W-1:0]     ra0;
  logic [ADDR_W-1:0]     ra1;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [WORD_BITS-1:0]  wr_data;

  logic                  take;
  logic [POS_W:0]        cur_idx1;
  logic                  cur_idx1_ok;
  logic [POS_W:0]        head_idx1;
  logic [POS_W:0]        fill_top;
  logic [WORD_BITS-1:0]  v0;
  logic [WORD_BITS-1:0]  v1;
  logic [OFF_W-1:0]      sh;
  logic [2*WORD_BITS-1:0] pair;
  logic [2*WORD_BITS-1:0] spread;
  logic [DATA_W-1:0]     rdv;

  assign job_ready = state == S_IDLE;
  assign take      = job_valid && job_ready;
  assign out_valid = state == S_DONE;

  // Both words of the item at the queue head are fetched as it is taken.
  always_comb begin
    head_idx1 = {1'b0, job.idx} + (POS_W + 1)'(1);
    ra0       = job.idx[ADDR_W-1:0];
    ra1       = (head_idx1 < STORE_LIM) ? head_idx1[ADDR_W-1:0] : ra0;
  end

  // Words past the fill level were never written and read as zero.
  always_comb begin
    cur_idx1    = {1'b0, cur.idx} + (POS_W + 1)'(1);
    cur_idx1_ok = cur_idx1 < STORE_LIM;
    v0 = ({1'b0, cur.idx} < (POS_W + 1)'(filled)) ? rd0 : '0;
    v1 = (cur_idx1_ok && (cur_idx1 < (POS_W + 1)'(filled))) ? rd1 : '0;
    sh = cur.sh[OFF_W-1:0];
    pair   = {v1, v0} >> sh;
    rdv    = DATA_W'(pair[WORD_BITS-1:0]) & bfpu_pkg::low_mask(cur.len);
    spread = {{WORD_BITS{1'b0}}, cur.data[WORD_BITS-1:0]} << sh;
    fill_top = (cur_idx1 + (POS_W + 1)'(1) > STORE_LIM) ? STORE_LIM
                                                        : cur_idx1 + (POS_W + 1)'(1);
  end

  // Store write port: low word of an append, then its spill word.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur.idx[ADDR_W-1:0];
    wr_data = v0 | spread[WORD_BITS-1:0];
    if (state == S_FETCH && cur.op == bfpu_pkg::OP_APPEND) begin
      wr_en = 1'b1;
    end else if (state == S_WR_HI) begin
      wr_en   = 1'b1;
      wr_addr = cur_idx1[ADDR_W-1:0];
      wr_data = spread[2*WORD_BITS-1:WORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      word_store[wr_addr] <= wr_data;
    end
    rd0 <= word_store[ra0];
    rd1 <= word_store[ra1];
  end

  // Sequencer and fill level.
  always_comb begin
    state_next  = state;
    filled_next = filled;
    case (state)
      S_IDLE: begin
        if (take) begin
          state_next = (job.op == bfpu_pkg::OP_RESULT) ? S_DONE : S_FETCH;
        end
      end
      S_FETCH: begin
        case (cur.op)
          bfpu_pkg::OP_APPEND: begin
            state_next = cur_idx1_ok ? S_WR_HI : S_DONE;
            if (fill_top > (POS_W + 1)'(filled)) begin
              filled_next = FILL_W'(fill_top);
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_WR_HI: state_next = S_DONE;
      S_DONE: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      filled <= '0;
    end else begin
      state  <= state_next;
      filled <= filled_next;
    end
  end

  // Current item and the result register.
  always_ff @(posedge clk) begin
    if (take) begin
      cur                <= job;
      read_data          <= '0;
      next_read_position <= job.next_rpos;
      write_position     <= job.wpos;
      status             <= job.status;
    end
    if (state == S_FETCH && cur.op == bfpu_pkg::OP_READ) begin
      read_data <= rdv;
    end
  end

endmodule

/* sv/bit_field_packer_unpacker_core.sv */
// Top level of the LSB-first bit field packer and reader.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_valid/cfg_ready  cfg_data (capacity in bits)
//   in       in         in_valid/in_ready    action, field_length, field_data, read_position
//   out      out        out_valid/out_ready  read_data, next_read_position, write_position, status
//
// An item is registered in the front stage and then in the queue before the back sequencer
// takes it. A rejected or empty item goes straight to the done state, a read through the fetch
// state; an append also needs a spill write state unless its word is the last of the store,
// as the word store has a single write port (an append writes two words). Up to two classified
// items wait in the queue, so input is taken while a result waits. Reset is synchronous; the
// store needs no clearing pass, a fill level marks written words. cfg_ready is always high.
module bit_field_packer_unpacker_core #(
  parameter int WORD_BITS   = bfpu_pkg::WORD_BITS_DEF,
  parameter int STORE_WORDS = bfpu_pkg::STORE_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bfpu_pkg::POS_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [bfpu_pkg::LEN_W-1:0]    field_length,
  input  logic [bfpu_pkg::DATA_W-1:0]   field_data,
  input  logic [bfpu_pkg::RPOS_W-1:0]   read_position,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bfpu_pkg::DATA_W-1:0]   read_data,
  output logic [bfpu_pkg::POS_W-1:0]    next_read_position,
  output logic [bfpu_pkg::POS_W-1:0]    write_position,
  output logic                          status
);

  logic           push_valid;
  logic           push_ready;
  bfpu_pkg::job_t push_job;
  logic           pop_valid;
  logic           pop_ready;
  bfpu_pkg::job_t pop_job;

  assign cfg_ready = 1'b1;

  bfpu_front #(
    .WORD_BITS   (WORD_BITS),
    .STORE_WORDS (STORE_WORDS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .field_length  (field_length),
    .field_data    (field_data),
    .read_position (read_position),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_job      (push_job)
  );

  bfpu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  bfpu_back #(
    .WORD_BITS   (WORD_BITS),
    .STORE_WORDS (STORE_WORDS)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .job_valid          (pop_valid),
    .job_ready          (pop_ready),
    .job                (pop_job),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .read_data          (read_data),
    .next_read_position (next_read_position),
    .write_position     (write_position),
    .status             (status)
  );

endmodule

/* sv/bfpu_checker.sv */
// Port-level checks of the packer core, bound to the top level.
module bfpu_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bfpu_pkg::DATA_W-1:0]   read_data,
  input logic [bfpu_pkg::POS_W-1:0]    next_read_position,
  input logic [bfpu_pkg::POS_W-1:0]    write_position,
  input logic                          status
);

  logic [bfpu_pkg::POS_W-1:0] last_wpos;

  // Write position of the last delivered item.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_wpos <= '0;
    end else if (out_valid && out_ready) begin
      last_wpos <= write_position;
    end
  end

  // A stalled result holds still.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) &&
      $stable(next_read_position) && $stable(write_position) && $stable(status))
    else $error("stalled result changed");

  // A rejected item never carries read data.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> read_data == '0)
    else $error("rejected item has nonzero read data");

  // The write pointer only moves forward.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> write_position >= last_wpos)
    else $error("write position went backward");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind bit_field_packer_unpacker_core bfpu_checker u_checker (.*);

/* tb/bit_field_packer_unpacker_core_tb.sv */
// Self-checking testbench for the LSB-first bit field packer and reader.
`timescale 1ns / 1ps

module bit_field_packer_unpacker_core_tb;

  localparam int WORD        = bfpu_pkg::WORD_BITS_DEF;
  localparam int STORE       = bfpu_pkg::STORE_WORDS_DEF;
  localparam int LEN_W       = bfpu_pkg::LEN_W;
  localparam int DATA_W      = bfpu_pkg::DATA_W;
  localparam int RPOS_W      = bfpu_pkg::RPOS_W;
  localparam int POS_W       = bfpu_pkg::POS_W;
  localparam int STORE_BITS  = WORD * STORE;
  localparam int SETTLE      = 8;
  localparam int STALL_LIMIT = 4000;

  // One field request as presented on the input channel.
  typedef struct packed {
    logic              act;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
    logic [RPOS_W-1:0] rpos;
  } field_req_t;

  // One result as seen on the output channel.
  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic [POS_W-1:0]  next_pos;
    logic [POS_W-1:0]  wpos;
    logic              status;
  } field_resp_t;

  typedef enum int {MIX_FIELDS, FILL_STREAM} stim_mode_t;

  // Mirror of the bitstream store that predicts every result and compares it.
  class bitstream_scoreboard;
    bit [WORD-1:0]  words [0:STORE-1];
    bit [POS_W-1:0] wptr;
    bit [POS_W-1:0] capacity = bfpu_pkg::CAP_RESET;
    field_resp_t    pending_fields [$];
    int errors;
    int n_append;
    int n_read;
    int n_reject;
    int n_store_end;

    function void set_capacity(bit [POS_W-1:0] value);
      capacity = value;
    endfunction

    function bit [DATA_W-1:0] low_bits(int len);
      return {DATA_W{1'b1}} >> (DATA_W - len);
    endfunction

    // Bounds check shared by appends and reads; also locates the word and offset.
    function bit access_ok(int pos, int len, output int idx, output int sh,
                           output bit spans);
      idx   = pos / WORD;
      sh    = pos % WORD;
      spans = (sh + len) > WORD;
      if (pos + len > int'(capacity)) return 1'b0;
      if (idx >= STORE || (spans && idx + 1 >= STORE)) begin
        n_store_end++;
        return 1'b0;
      end
      return 1'b1;
    endfunction

    // Work out the result of an accepted field request and update the mirror.
    function void note_field(field_req_t req);
      field_resp_t exp;
      int len;
      int idx;
      int sh;
      bit spans;
      bit [DATA_W-1:0] bits;
      exp = '0;
      len = int'(req.len);
      if (req.act == bfpu_pkg::ACT_READ) exp.next_pos = POS_W'(req.rpos);
      if (len > WORD) begin
        exp.status = 1'b1;
      end else if (len != 0) begin
        if (req.act == bfpu_pkg::ACT_APPEND) begin
          if (access_ok(int'(wptr), len, idx, sh, spans)) begin
            bits = req.data & low_bits(len);
            words[idx] |= bits << sh;
            // The following word, if inside the store, takes the spill, zero when nothing spills.
            if (idx + 1 < STORE) words[idx + 1] = (sh == 0) ? '0 : bits >> (WORD - sh);
            wptr = POS_W'(int'(wptr) + len);
            n_append++;
          end else begin
            exp.status = 1'b1;
          end
        end else begin
          if (access_ok(int'(req.rpos), len, idx, sh, spans)) begin
            bits = words[idx] >> sh;
            if (spans) bits |= words[idx + 1] << (WORD - sh);
            exp.rdata    = bits & low_bits(len);
            exp.next_pos = POS_W'(int'(req.rpos) + len);
            n_read++;
          end else begin
            exp.status = 1'b1;
          end
        end
      end
      if (exp.status) n_reject++;
      exp.wpos = wptr;
      pending_fields.push_back(exp);
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    // Compare one delivered result with the oldest prediction.
    task check_result(field_resp_t got);
      field_resp_t exp;
      if (pending_fields.size() == 0) begin
        report("result arrived with no field outstanding");
        return;
      end
      exp = pending_fields.pop_front();
      if (got.rdata !== exp.rdata)
        report($sformatf("read_data %h, expected %h", got.rdata, exp.rdata));
      if (got.next_pos !== exp.next_pos)
        report($sformatf("next_read_position %0d, expected %0d", got.next_pos,
                         exp.next_pos));
      if (got.wpos !== exp.wpos)
        report($sformatf("write_position %0d, expected %0d", got.wpos, exp.wpos));
      if (got.status !== exp.status)
        report($sformatf("status %b, expected %b", got.status, exp.status));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [POS_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = bfpu_pkg::ACT_APPEND;
  logic [LEN_W-1:0] field_length = '0;
  logic [DATA_W-1:0] field_data = '0;
  logic [RPOS_W-1:0] read_position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DATA_W-1:0] read_data;
  logic [POS_W-1:0] next_read_position;
  logic [POS_W-1:0] write_position;
  logic status;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int n_fields = 0;

  bitstream_scoreboard sb = new();

  bit_field_packer_unpacker_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .field_length(field_length),
    .field_data(field_data),
    .read_position(read_position),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_data(read_data),
    .next_read_position(next_read_position),
    .write_position(write_position),
    .status(status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver backpressure, redrawn every cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watch all three channels: feed the scoreboard and track progress.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_capacity(cfg_data);
      if (in_valid && in_ready) begin
        sb.note_field(field_req_t'{action, field_length, field_data, read_position});
        n_fields++;
      end
      if (out_valid && out_ready)
        sb.check_result(field_resp_t'{read_data, next_read_position, write_position,
                                      status});
    end
  end

  // Watchdog on cycles in which nothing at all is accepted.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int clamp_pos(int pos);
    if (pos < 0) return 0;
    if (pos > 65535) return 65535;
    return pos;
  endfunction

  // Draw the next random field request for the given stimulus mode.
  function automatic field_req_t next_field(stim_mode_t mode);
    field_req_t req;
    int pick;
    int len;
    int pos;
    req.data = {$urandom, $urandom};
    if (mode == FILL_STREAM) begin
      // Mostly full-width appends, with a few reads of what is already written.
      if ($urandom_range(99) < 92) begin
        req.act = bfpu_pkg::ACT_APPEND;
        if (sb.wptr < STORE_BITS && sb.wptr > STORE_BITS - WORD && $urandom_range(3) == 0)
          len = STORE_BITS - int'(sb.wptr);
        else if ($urandom_range(99) < 88)
          len = WORD;
        else
          len = int'($urandom_range(127));
        pos = int'($urandom_range(65535));
      end else begin
        req.act = bfpu_pkg::ACT_READ;
        len = int'($urandom_range(1, WORD));
        pos = int'($urandom_range(0, sb.wptr));
      end
    end else begin
      req.act = 1'($urandom_range(1));
      pick = int'($urandom_range(99));
      if (pick < 5) len = 0;
      else if (pick < 11) len = int'($urandom_range(WORD + 1, 127));
      else if (pick < 26) len = WORD;
      else len = int'($urandom_range(1, WORD - 1));
      // Read positions: anywhere, inside the written part, or around the capacity edge.
      pick = int'($urandom_range(99));
      if (pick < 40) pos = int'($urandom_range(65535));
      else if (pick < 75) pos = int'($urandom_range(0, sb.wptr));
      else pos = int'(sb.capacity) - len + int'($urandom_range(2)) - 1;
    end
    req.len  = LEN_W'(len);
    req.rpos = RPOS_W'(clamp_pos(pos));
    return req;
  endfunction

  task automatic send_item(field_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= req.act;
    field_length  <= req.len;
    field_data    <= req.data;
    read_position <= req.rpos;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait until every predicted result has been delivered.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_fields.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(logic [POS_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_fields(int count, stim_mode_t mode);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(199) == 0) wait_drained();
      send_item(next_field(mode));
    end
  endtask

  task automatic set_idling(int send_pct, int stall);
    send_idle_pct = send_pct;
    stall_pct     = stall;
  endtask

  initial begin
    int guard;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed fields at the reset capacity.
    send_item(field_req_t'{bfpu_pkg::ACT_APPEND, 7'd0, {DATA_W{1'b1}}, 16'd0});
    send_item(field_req_t'{bfpu_pkg::ACT_READ, 7'd0, 64'd0, 16'hFFFF});
    send_item(field_req_t'{bfpu_pkg::ACT_APPEND, 7'd65, {DATA_W{1'b1}}, 16'd0});
    send_item(field_req_t'{bfpu_pkg::ACT_APPEND, 7'd127, {DATA_W{1'b1}}, 16'd0});
    send_item(field_req_t'{bfpu_pkg::ACT_READ, 7'd127, 64'd0, 16'd5});
    send_item(field_req_t'{bfpu_pkg::ACT_APPEND, 7'd1, {DATA_W{1'b1}}, 16'd0});
    send_item(field_req_t'{bfpu_pkg::ACT_APPEND, 7'd64, {DATA_W{1'b1}}, 16'd0});
    send_item(field_req_t'{bfpu_pkg::ACT_APPEND, 7'd63, 64'hAAAA_AAAA_AAAA_AAAA, 16'd0});
    send_item(field_req_t'{bfpu_pkg::ACT_APPEND, 7'd64, 64'h8000_0000_0000_0001, 16'd0});
    send_item(field_req_t'{bfpu_pkg::ACT_READ, 7'd64, 64'd0, 16'd0});
    send_item(field_req_t'{bfpu_pkg::ACT_READ, 7'd64, 64'd0, 16'd1});
    send_item(field_req_t'{bfpu_pkg::ACT_READ, 7'd1, 64'd0, 16'd64});
    send_item(field_req_t'{bfpu_pkg::ACT_READ, 7'd63, {DATA_W{1'b1}}, 16'd65});
    send_item(field_req_t'{bfpu_pkg::ACT_READ, 7'd1, 64'd0, 16'hFFFF});
    send_item(field_req_t'{bfpu_pkg::ACT_READ, 7'd2, 64'd0, 16'hFFFF});
    send_item(field_req_t'{bfpu_pkg::ACT_READ, 7'd64, 64'd0, 16'hFFC0});
    send_item(field_req_t'{bfpu_pkg::ACT_APPEND, 7'd7, 64'h0123_4567_89AB_CDEF, 16'd0});
    send_item(field_req_t'{bfpu_pkg::ACT_READ, 7'd37, 64'd0, 16'd190});
    send_item(field_req_t'{bfpu_pkg::ACT_APPEND, 7'd64, 64'd0, 16'hFFFF});
    send_item(field_req_t'{bfpu_pkg::ACT_APPEND, 7'd64, 64'hFEDC_BA98_7654_3210, 16'd0});
    send_item(field_req_t'{bfpu_pkg::ACT_READ, 7'd64, 64'd0, 16'd230});
    send_item(field_req_t'{bfpu_pkg::ACT_READ, 7'd64, 64'd0, 16'h8000});

    // Smallest capacity: almost every access is rejected.
    write_capacity(17'd1);
    set_idling(0, 0);
    run_fields(50, MIX_FIELDS);

    // Capacity a little past the write pointer, so the edge is reached.
    write_capacity(sb.wptr + 17'd700);
    set_idling(61, 0);
    run_fields(70, MIX_FIELDS);

    // Full stream capacity; mostly appends that push the pointer far.
    write_capacity(bfpu_pkg::CAP_RESET);
    set_idling(0, 61);
    run_fields(400, FILL_STREAM);

    // Largest capacity: fill to the end of the word store, then probe past it.
    write_capacity(17'h1FFFF);
    set_idling(21, 21);
    guard = 0;
    while (sb.wptr < STORE_BITS && guard < 900) begin
      send_item(next_field(FILL_STREAM));
      guard++;
    end
    run_fields(50, MIX_FIELDS);

    wait_drained();
    $display("Covered %0d fields: %0d appends and %0d reads taken, %0d rejected",
             n_fields, sb.n_append, sb.n_read, sb.n_reject);
    $display("Rejected at the end of the word store: %0d; final write pointer %0d",
             sb.n_store_end, sb.wptr);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* bit_field_packer_unpacker_core.f */
sv/bfpu_pkg.sv
sv/bfpu_front.sv
sv/bfpu_queue.sv
sv/bfpu_back.sv
sv/bit_field_packer_unpacker_core.sv
sv/bfpu_checker.sv
tb/bit_field_packer_unpacker_core_tb.sv
